@@ design/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the colour space converter
// Channel format, hue constants, reciprocal for the fixed divide and the
// sideband carried through the divider pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam logic [CHANNEL_BITS-1:0] CMAX = '1;

   localparam int FIRST_W = 9;
   localparam int FIELD_W = 8;

   localparam int HUE_FULL   = 360;
   localparam int HUE_SECTOR = 60;
   localparam int SECT_W     = 3;
   localparam int FRAC_W     = $clog2(HUE_SECTOR);

   // constant divide by 60*CMAX, rounded: floor((2n + DEN) / (2*DEN))
   localparam int    DEN     = HUE_SECTOR * ((1 << CHANNEL_BITS) - 1);
   localparam int    DEN_W   = $clog2(DEN + 1);
   localparam int    PROD_W  = CHANNEL_BITS + DEN_W;
   localparam int    CN_W    = PROD_W + 1;
   localparam int    CD2     = 2 * DEN;
   localparam longint RECIP  = (64'd1 << CN_W) / CD2;
   localparam int    RECIP_W = $clog2(RECIP + 1);

   // pipelined restoring divider
   localparam int DIV_NW    = CHANNEL_BITS + 10;
   localparam int DIV_DW    = CHANNEL_BITS + 1;
   localparam int DIV_QW    = (CHANNEL_BITS > FIRST_W) ? CHANNEL_BITS : FIRST_W;
   localparam int DIV_LANES = 5;
   localparam int LANE_C    = 0;
   localparam int LANE_M    = 1;
   localparam int LANE_Y    = 2;
   localparam int LANE_S    = 3;
   localparam int LANE_H    = 4;

   localparam int REG_MODE = 0;

   typedef enum logic [2:0] {
      MODE_RGB_CMYK = 3'd0,
      MODE_RGB_HSV  = 3'd1,
      MODE_CMYK_RGB = 3'd2,
      MODE_CMYK_HSV = 3'd3,
      MODE_HSV_RGB  = 3'd4,
      MODE_HSV_CMYK = 3'd5
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic [CHANNEL_BITS-1:0] vmax;
      logic                    grey;
   } csc_side_type;

endpackage

@@ design/csc_req_if.sv @@
// ----------------------------------------------------------------------------
// csc_req_if: input colour channel
// One colour per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csc_req_if import csc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIRST_W-1:0] in_first;
   logic [FIELD_W-1:0] in_second;
   logic [FIELD_W-1:0] in_third;
   logic [FIELD_W-1:0] in_fourth;

   modport source (output valid, in_first, in_second, in_third, in_fourth, input ready);
   modport sink   (input valid, in_first, in_second, in_third, in_fourth, output ready);
endinterface

@@ design/csc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// csc_rsp_if: result colour channel
// One converted colour per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csc_rsp_if import csc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIRST_W-1:0] out_first;
   logic [FIELD_W-1:0] out_second;
   logic [FIELD_W-1:0] out_third;
   logic [FIELD_W-1:0] out_fourth;
   logic               hue_undefined;

   modport source (output valid, out_first, out_second, out_third, out_fourth,
                   hue_undefined, input ready);
   modport sink   (input valid, out_first, out_second, out_third, out_fourth,
                   hue_undefined, output ready);
endinterface

@@ design/color_space_converter.sv @@
// ----------------------------------------------------------------------------
// color_space_converter: RGB / CMYK / HSV conversion pipeline
// Front end turns CMYK or HSV into RGB with a constant divide, back end
// turns RGB into CMYK or HSV through a pipelined divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | valid/ready        | in_first..in_fourth
//  rsp     | out       | valid/ready        | out_first..out_fourth, hue_undefined
//  apb     | in        | psel/penable/pready| conversion_mode at byte address 0
//
//  One item per clock while rsp is not stalled; an item passes through the nine
//  front stages, the one-bit-per-stage divider and the output register.
//  Reset (synchronous) clears the valid bits and the mode register.
//  A stall on rsp freezes every stage together; req.ready drops only while
//  the output register holds an item that has not been taken.
// ----------------------------------------------------------------------------
module color_space_converter import csc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   csc_req_if.sink     req,
   csc_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CB = CHANNEL_BITS;

   typedef struct packed {
      mode_type               mode;
      logic [2:0][CB-1:0]     ch;
      logic [CB-1:0]          v;
      logic                   szero;
      logic [SECT_W-1:0]      sector;
   } front_type;

   // ---------------- configuration ----------------
   mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RGB_CMYK;
      end else if (psel && penable && pwrite && pready && paddr[2] == 1'(REG_MODE)) begin
         mode_ff <= mode_type'(pwdata[2:0]);
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'(REG_MODE)) ? 32'(mode_ff) : '0;

   // ---------------- flow control ----------------
   logic rsp_valid_ff;
   logic en;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   function automatic logic [CB-1:0] sat_ch(input logic [FIRST_W-1:0] x);
      return (32'(x) > 32'(CMAX)) ? CMAX : CB'(x);
   endfunction

   // ---------------- S1: saturate, wrap hue ----------------
   logic               s1_valid_ff;
   mode_type           s1_mode_ff;
   logic [CB-1:0]      s1_ch_ff [4];
   logic [FIRST_W-1:0] s1_hue_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mode_ff  <= mode_ff;
         s1_ch_ff[0] <= sat_ch(req.in_first);
         s1_ch_ff[1] <= sat_ch(FIRST_W'(req.in_second));
         s1_ch_ff[2] <= sat_ch(FIRST_W'(req.in_third));
         s1_ch_ff[3] <= sat_ch(FIRST_W'(req.in_fourth));
         s1_hue_ff   <= (req.in_first >= FIRST_W'(HUE_FULL))
                        ? req.in_first - FIRST_W'(HUE_FULL) : req.in_first;
      end
   end

   // ---------------- S2: hue sector and fraction ----------------
   logic               s2_valid_ff;
   mode_type           s2_mode_ff;
   logic [CB-1:0]      s2_ch_ff [4];
   logic [SECT_W-1:0]  s2_sector_ff;
   logic [FRAC_W-1:0]  s2_frac_ff;
   logic [SECT_W-1:0]  s2_sector_in;
   logic [FRAC_W-1:0]  s2_frac_in;

   always_comb begin
      s2_sector_in = '0;
      for (int k = 1; k < 6; k++) begin
         if (s1_hue_ff >= FIRST_W'(HUE_SECTOR * k)) s2_sector_in = s2_sector_in + 1'b1;
      end
      s2_frac_in = FRAC_W'(s1_hue_ff - FIRST_W'(HUE_SECTOR * int'(s2_sector_in)));
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (en) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mode_ff   <= s1_mode_ff;
         s2_ch_ff     <= s1_ch_ff;
         s2_sector_ff <= s2_sector_in;
         s2_frac_ff   <= s2_frac_in;
      end
   end

   // ---------------- S3: factor and weights ----------------
   logic             s3_valid_ff;
   front_type        s3_front_ff, s3_front_in;
   logic [CB-1:0]    s3_factor_ff, s3_factor_in;
   logic [DEN_W-1:0] s3_w_ff [3];
   logic [DEN_W-1:0] s3_w_in [3];

   always_comb begin
      s3_front_in.mode   = s2_mode_ff;
      s3_front_in.ch     = {s2_ch_ff[2], s2_ch_ff[1], s2_ch_ff[0]};
      s3_front_in.v      = s2_ch_ff[2];
      s3_front_in.szero  = (s2_ch_ff[1] == '0);
      s3_front_in.sector = s2_sector_ff;
      if (s2_mode_ff == MODE_HSV_RGB || s2_mode_ff == MODE_HSV_CMYK) begin
         s3_factor_in = s2_ch_ff[2];
         s3_w_in[0] = DEN_W'(DEN - HUE_SECTOR * int'(s2_ch_ff[1]));
         s3_w_in[1] = DEN_W'(DEN - int'(s2_ch_ff[1]) * int'(s2_frac_ff));
         s3_w_in[2] = DEN_W'(DEN - int'(s2_ch_ff[1]) * (HUE_SECTOR - int'(s2_frac_ff)));
      end else begin
         s3_factor_in = CMAX - s2_ch_ff[3];
         for (int i = 0; i < 3; i++) begin
            s3_w_in[i] = DEN_W'(HUE_SECTOR * (int'(CMAX) - int'(s2_ch_ff[i])));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (en) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_front_ff  <= s3_front_in;
         s3_factor_ff <= s3_factor_in;
         s3_w_ff      <= s3_w_in;
      end
   end

   // ---------------- S4: products ----------------
   logic              s4_valid_ff;
   front_type         s4_front_ff;
   logic [PROD_W-1:0] s4_prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (en) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_front_ff <= s3_front_ff;
         for (int i = 0; i < 3; i++) begin
            s4_prod_ff[i] <= PROD_W'(s3_factor_ff) * PROD_W'(s3_w_ff[i]);
         end
      end
   end

   // ---------------- S5: reciprocal estimate ----------------
   localparam int EST_W = CN_W + RECIP_W;

   logic               s5_valid_ff;
   front_type          s5_front_ff;
   logic [CN_W-1:0]    s5_num_ff [3];
   logic [RECIP_W-1:0] s5_qe_ff  [3];
   logic [CN_W-1:0]    s5_num_in [3];
   logic [EST_W-1:0]   s5_est    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_num_in[i] = {s4_prod_ff[i], 1'b0} + CN_W'(DEN);
         s5_est[i]    = EST_W'(s5_num_in[i]) * EST_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (en) s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_front_ff <= s4_front_ff;
         s5_num_ff   <= s5_num_in;
         for (int i = 0; i < 3; i++) begin
            s5_qe_ff[i] <= s5_est[i][CN_W +: RECIP_W];
         end
      end
   end

   // ---------------- S6: correct the estimate by one ----------------
   logic            s6_valid_ff;
   front_type       s6_front_ff;
   logic [CB-1:0]   s6_quo_ff [3];
   logic [CB-1:0]   s6_quo_in [3];
   logic [CN_W-1:0] s6_rem    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_rem[i]    = s5_num_ff[i] - CN_W'(CN_W'(s5_qe_ff[i]) * CN_W'(CD2));
         s6_quo_in[i] = (s6_rem[i] >= CN_W'(CD2)) ? CB'(s5_qe_ff[i] + 1'b1)
                                                  : CB'(s5_qe_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else if (en) s6_valid_ff <= s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_front_ff <= s5_front_ff;
         s6_quo_ff   <= s6_quo_in;
      end
   end

   // ---------------- S7: select RGB ----------------
   logic          s7_valid_ff;
   mode_type      s7_mode_ff;
   logic [CB-1:0] s7_rgb_ff [3];
   logic [CB-1:0] s7_rgb_in [3];
   logic [CB-1:0] hp, hq, ht, hv;

   always_comb begin
      hp = s6_quo_ff[0];
      hq = s6_quo_ff[1];
      ht = s6_quo_ff[2];
      hv = s6_front_ff.v;
      for (int i = 0; i < 3; i++) s7_rgb_in[i] = '0;
      case (s6_front_ff.mode) inside
         MODE_RGB_CMYK, MODE_RGB_HSV: begin
            for (int i = 0; i < 3; i++) s7_rgb_in[i] = s6_front_ff.ch[i];
         end
         MODE_CMYK_RGB, MODE_CMYK_HSV: begin
            s7_rgb_in = s6_quo_ff;
         end
         MODE_HSV_RGB, MODE_HSV_CMYK: begin
            if (s6_front_ff.szero) begin
               for (int i = 0; i < 3; i++) s7_rgb_in[i] = hv;
            end else begin
               case (s6_front_ff.sector)
                  3'd0:    begin s7_rgb_in[0] = hv; s7_rgb_in[1] = ht; s7_rgb_in[2] = hp; end
                  3'd1:    begin s7_rgb_in[0] = hq; s7_rgb_in[1] = hv; s7_rgb_in[2] = hp; end
                  3'd2:    begin s7_rgb_in[0] = hp; s7_rgb_in[1] = hv; s7_rgb_in[2] = ht; end
                  3'd3:    begin s7_rgb_in[0] = hp; s7_rgb_in[1] = hq; s7_rgb_in[2] = hv; end
                  3'd4:    begin s7_rgb_in[0] = ht; s7_rgb_in[1] = hp; s7_rgb_in[2] = hv; end
                  default: begin s7_rgb_in[0] = hv; s7_rgb_in[1] = hp; s7_rgb_in[2] = hq; end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s7_valid_ff <= 1'b0;
      else if (en) s7_valid_ff <= s6_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_mode_ff <= s6_front_ff.mode;
         s7_rgb_ff  <= s7_rgb_in;
      end
   end

   // ---------------- S8: max and min ----------------
   logic          s8_valid_ff;
   mode_type      s8_mode_ff;
   logic [CB-1:0] s8_rgb_ff [3];
   logic [CB-1:0] s8_mx_ff, s8_mn_ff;
   logic [CB-1:0] s8_mx_in, s8_mn_in;

   always_comb begin
      s8_mx_in = (s7_rgb_ff[0] > s7_rgb_ff[1]) ? s7_rgb_ff[0] : s7_rgb_ff[1];
      if (s7_rgb_ff[2] > s8_mx_in) s8_mx_in = s7_rgb_ff[2];
      s8_mn_in = (s7_rgb_ff[0] < s7_rgb_ff[1]) ? s7_rgb_ff[0] : s7_rgb_ff[1];
      if (s7_rgb_ff[2] < s8_mn_in) s8_mn_in = s7_rgb_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) s8_valid_ff <= 1'b0;
      else if (en) s8_valid_ff <= s7_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_mode_ff <= s7_mode_ff;
         s8_rgb_ff  <= s7_rgb_ff;
         s8_mx_ff   <= s8_mx_in;
         s8_mn_ff   <= s8_mn_in;
      end
   end

   // ---------------- S9: divider operands ----------------
   logic              s9_valid_ff;
   logic [DIV_NW-1:0] s9_num_ff [DIV_LANES];
   logic [DIV_DW-1:0] s9_den_ff [DIV_LANES];
   csc_side_type      s9_side_ff;
   logic [DIV_NW-1:0] s9_num_in [DIV_LANES];
   logic [DIV_DW-1:0] s9_den_in [DIV_LANES];
   csc_side_type      s9_side_in;
   logic [CB-1:0]     s9_d;
   longint            s9_n;

   always_comb begin
      s9_d = s8_mx_ff - s8_mn_ff;
      if (s8_rgb_ff[0] == s8_mx_ff) begin
         // red is largest: fold a negative numerator up by a full turn
         if (s8_rgb_ff[1] >= s8_rgb_ff[2])
            s9_n = longint'(s8_rgb_ff[1]) - longint'(s8_rgb_ff[2]);
         else
            s9_n = 6 * longint'(s9_d) - (longint'(s8_rgb_ff[2]) - longint'(s8_rgb_ff[1]));
      end else if (s8_rgb_ff[1] == s8_mx_ff) begin
         s9_n = 2 * longint'(s9_d) + longint'(s8_rgb_ff[2]) - longint'(s8_rgb_ff[0]);
      end else begin
         s9_n = 4 * longint'(s9_d) + longint'(s8_rgb_ff[0]) - longint'(s8_rgb_ff[1]);
      end
      for (int i = 0; i < 3; i++) begin
         s9_num_in[i] = DIV_NW'(2 * longint'(CMAX) * (longint'(s8_mx_ff) - longint'(s8_rgb_ff[i]))
                                + longint'(s8_mx_ff));
         s9_den_in[i] = {s8_mx_ff, 1'b0};
      end
      s9_num_in[LANE_S] = DIV_NW'(2 * longint'(CMAX) * longint'(s9_d) + longint'(s8_mx_ff));
      s9_den_in[LANE_S] = {s8_mx_ff, 1'b0};
      s9_num_in[LANE_H] = DIV_NW'(2 * HUE_SECTOR * s9_n + longint'(s9_d));
      s9_den_in[LANE_H] = {s9_d, 1'b0};
      s9_side_in.mode  = s8_mode_ff;
      s9_side_in.red   = s8_rgb_ff[0];
      s9_side_in.green = s8_rgb_ff[1];
      s9_side_in.blue  = s8_rgb_ff[2];
      s9_side_in.vmax  = s8_mx_ff;
      s9_side_in.grey  = (s9_d == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) s9_valid_ff <= 1'b0;
      else if (en) s9_valid_ff <= s8_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_num_ff  <= s9_num_in;
         s9_den_ff  <= s9_den_in;
         s9_side_ff <= s9_side_in;
      end
   end

   // ---------------- divider ----------------
   logic              dv_valid;
   logic [DIV_QW-1:0] dv_quo [DIV_LANES];
   csc_side_type      dv_side;

   csc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s9_valid_ff),
      .in_num    (s9_num_ff),
      .in_den    (s9_den_ff),
      .in_side   (s9_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ---------------- output register ----------------
   logic [FIRST_W-1:0] first_ff, first_in;
   logic [FIELD_W-1:0] second_ff, second_in;
   logic [FIELD_W-1:0] third_ff, third_in;
   logic [FIELD_W-1:0] fourth_ff, fourth_in;
   logic               undef_ff, undef_in;
   logic [DIV_QW-1:0]  hue_wrap;
   logic               black;

   always_comb begin
      black    = (dv_side.vmax == '0);
      hue_wrap = (dv_quo[LANE_H] >= DIV_QW'(HUE_FULL))
                 ? dv_quo[LANE_H] - DIV_QW'(HUE_FULL) : dv_quo[LANE_H];
      first_in  = '0;
      second_in = '0;
      third_in  = '0;
      fourth_in = '0;
      undef_in  = 1'b0;
      case (dv_side.mode) inside
         MODE_RGB_CMYK, MODE_HSV_CMYK: begin
            fourth_in = FIELD_W'(CMAX - dv_side.vmax);
            if (!black) begin
               first_in  = FIRST_W'(dv_quo[LANE_C]);
               second_in = FIELD_W'(dv_quo[LANE_M]);
               third_in  = FIELD_W'(dv_quo[LANE_Y]);
            end
         end
         MODE_RGB_HSV, MODE_CMYK_HSV: begin
            if (black) begin
               undef_in = 1'b1;
            end else begin
               first_in  = dv_side.grey ? '0 : FIRST_W'(hue_wrap);
               second_in = FIELD_W'(dv_quo[LANE_S]);
               third_in  = FIELD_W'(dv_side.vmax);
            end
         end
         MODE_CMYK_RGB, MODE_HSV_RGB: begin
            first_in  = FIRST_W'(dv_side.red);
            second_in = FIELD_W'(dv_side.green);
            third_in  = FIELD_W'(dv_side.blue);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= dv_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         fourth_ff <= fourth_in;
         undef_ff  <= undef_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_first     = first_ff;
   assign rsp.out_second    = second_ff;
   assign rsp.out_third     = third_ff;
   assign rsp.out_fourth    = fourth_ff;
   assign rsp.hue_undefined = undef_ff;

   // ---------------- assertions ----------------
   a_undef_black : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hue_undefined |->
         rsp.out_first == '0 && rsp.out_second == '0 && rsp.out_third == '0
         && rsp.out_fourth == '0)
      else $error("hue_undefined with non-zero fields");

   a_first_range : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.out_first < FIRST_W'(HUE_FULL))
      else $error("out_first beyond 359");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid straight after reset");

endmodule

@@ design/csc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// csc_div_pipe: multi-lane pipelined restoring divider
// One quotient bit per stage, most significant first; a sideband struct and
// a valid bit travel with each item.
// ----------------------------------------------------------------------------
module csc_div_pipe import csc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic [DIV_NW-1:0]  in_num [DIV_LANES],
   input  logic [DIV_DW-1:0]  in_den [DIV_LANES],
   input  csc_side_type       in_side,
   output logic               out_valid,
   output logic [DIV_QW-1:0]  out_quo [DIV_LANES],
   output csc_side_type       out_side
);

   localparam int EXT_W = DIV_NW + DIV_QW;

   logic [DIV_NW-1:0] rem_src [DIV_QW][DIV_LANES];
   logic [DIV_NW-1:0] rem_in  [DIV_QW][DIV_LANES];
   logic [DIV_NW-1:0] rem_ff  [DIV_QW][DIV_LANES];
   logic [DIV_QW-1:0] quo_src [DIV_QW][DIV_LANES];
   logic [DIV_QW-1:0] quo_in  [DIV_QW][DIV_LANES];
   logic [DIV_QW-1:0] quo_ff  [DIV_QW][DIV_LANES];
   logic [DIV_DW-1:0] den_src [DIV_QW][DIV_LANES];
   logic [DIV_DW-1:0] den_ff  [DIV_QW][DIV_LANES];
   csc_side_type      side_src [DIV_QW];
   csc_side_type      side_ff  [DIV_QW];
   logic              valid_src [DIV_QW];
   logic              valid_ff  [DIV_QW];

   for (genvar g = 0; g < DIV_QW; g++) begin : g_stage
      localparam int BIT = DIV_QW - 1 - g;

      if (g == 0) begin : g_head
         assign side_src[g]  = in_side;
         assign valid_src[g] = in_valid;
         for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
            assign rem_src[g][l] = in_num[l];
            assign quo_src[g][l] = '0;
            assign den_src[g][l] = in_den[l];
         end
      end else begin : g_body
         assign side_src[g]  = side_ff[g-1];
         assign valid_src[g] = valid_ff[g-1];
         for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
            assign rem_src[g][l] = rem_ff[g-1][l];
            assign quo_src[g][l] = quo_ff[g-1][l];
            assign den_src[g][l] = den_ff[g-1][l];
         end
      end

      for (genvar l = 0; l < DIV_LANES; l++) begin : g_step
         logic [EXT_W-1:0] trial;
         logic             take;
         assign trial = EXT_W'(den_src[g][l]) << BIT;
         assign take  = EXT_W'(rem_src[g][l]) >= trial;
         assign rem_in[g][l] = take ? DIV_NW'(EXT_W'(rem_src[g][l]) - trial)
                                    : rem_src[g][l];
         assign quo_in[g][l] = quo_src[g][l] | (DIV_QW'(take) << BIT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (enable) begin
            valid_ff[g] <= valid_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g]  <= rem_in[g];
            quo_ff[g]  <= quo_in[g];
            den_ff[g]  <= den_src[g];
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign out_valid = valid_ff[DIV_QW-1];
   assign out_quo   = quo_ff[DIV_QW-1];
   assign out_side  = side_ff[DIV_QW-1];

endmodule
